// File: sv/fctc_pkg.sv
// Shared types, constants and helper functions of the floor texture coordinate caster.
`default_nettype none
package fctc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MAP_BITS  = 6;
  localparam int unsigned POS_W     = MAP_BITS + FRAC_BITS;
  localparam int unsigned FPT_W     = POS_W + 1;
  localparam int unsigned H_W       = 11;
  localparam int unsigned DIST_W    = H_W + FRAC_BITS;
  localparam int unsigned WD_W      = 24;
  localparam int unsigned W_BITS    = FRAC_BITS;
  localparam int unsigned DIV1_STEPS = DIST_W;
  localparam int unsigned NSTG      = DIV1_STEPS + 1 + W_BITS;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_AW      = 2;

  localparam logic [1:0] DIR_POS = 2'd1;
  localparam logic [1:0] DIR_NEG = 2'd2;

  localparam logic [1:0] REG_SCREEN_H = 2'd0;
  localparam logic [1:0] REG_TEX_W    = 2'd1;
  localparam logic [1:0] REG_TEX_H    = 2'd2;

  typedef struct packed {
    logic [9:0]        column;
    logic [9:0]        row;
    logic [10:0]       ceil_row;
    logic [FPT_W-1:0]  fx;
    logic [FPT_W-1:0]  fy;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [WD_W-1:0]   wdist;
    logic [9:0]        denom;
    logic [H_W-1:0]    h;
  } item_t;

  typedef struct packed {
    item_t              it;
    logic [9:0]         rem1;
    logic [DIST_W-1:0]  rdist;
    logic [WD_W-1:0]    rem2;
    logic [W_BITS-1:0]  wq;
    logic               sat;
  } back_t;

  function automatic logic [10:0] tex_clamp(logic [10:0] t);
    if (t == 11'd0) begin
      return 11'd1;
    end else if (t > 11'd1024) begin
      return 11'd1024;
    end
    return t;
  endfunction

  // One step of the back pipeline: a bit of the row distance, the weight
  // set-up, or a bit of the weight.
  function automatic back_t back_step(back_t b, int unsigned s);
    back_t             n;
    logic [10:0]       r1;
    logic [WD_W:0]     r2;
    logic [DIST_W-1:0] num;
    int unsigned       i;
    n   = b;
    num = {b.it.h, {FRAC_BITS{1'b0}}};
    r1  = '0;
    r2  = '0;
    i   = 0;
    if (s < DIV1_STEPS) begin
      i  = DIST_W - 1 - s;
      r1 = {b.rem1, num[i]};
      if (r1 >= {1'b0, b.it.denom}) begin
        r1 = r1 - {1'b0, b.it.denom};
        n.rdist[i] = 1'b1;
      end
      n.rem1 = r1[9:0];
    end else if (s == DIV1_STEPS) begin
      if (b.it.wdist == '0) begin
        n.it.wdist = WD_W'(1);
      end
      n.sat  = (b.rdist >= DIST_W'(n.it.wdist));
      n.rem2 = b.rdist[WD_W-1:0];
      n.wq   = '0;
    end else begin
      i  = W_BITS - 1 - (s - DIV1_STEPS - 1);
      r2 = {b.rem2, 1'b0};
      if (r2 >= {1'b0, b.it.wdist}) begin
        r2 = r2 - {1'b0, b.it.wdist};
        n.wq[i] = 1'b1;
      end
      n.rem2 = r2[WD_W-1:0];
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: sv/fctc_front.sv
// Front end: accepts a request, drops rows without floor, picks the wall floor point.
`default_nettype none
module fctc_front (
  input  wire logic                       start_i,
  input  wire logic                       busy_i,
  input  wire logic [10:0]                screen_h_i,
  input  wire logic [9:0]                 column_i,
  input  wire logic [9:0]                 row_i,
  input  wire logic                       side_i,
  input  wire logic [1:0]                 ray_x_dir_i,
  input  wire logic [1:0]                 ray_y_dir_i,
  input  wire logic [5:0]                 map_x_i,
  input  wire logic [5:0]                 map_y_i,
  input  wire logic [15:0]                wall_hit_frac_i,
  input  wire logic [23:0]                wall_dist_i,
  input  wire logic signed [10:0]         draw_end_i,
  input  wire logic [21:0]                pos_x_i,
  input  wire logic [21:0]                pos_y_i,
  output logic                            push_o,
  output fctc_pkg::item_t                 item_o
);
  import fctc_pkg::*;

  logic             keep;
  logic [10:0]      row2;
  logic [FPT_W-1:0] mx, my, fr, one;

  always_comb begin
    row2 = {row_i, 1'b0};
    keep = !draw_end_i[10] && (row_i > draw_end_i[9:0]) &&
           ({1'b0, row_i} < screen_h_i) && (row2 > screen_h_i);
    push_o = start_i && !busy_i && keep;
  end

  always_comb begin
    mx  = FPT_W'({map_x_i, {FRAC_BITS{1'b0}}});
    my  = FPT_W'({map_y_i, {FRAC_BITS{1'b0}}});
    fr  = FPT_W'(wall_hit_frac_i);
    one = FPT_W'(1) << FRAC_BITS;
    item_o.column   = column_i;
    item_o.row      = row_i;
    item_o.ceil_row = screen_h_i - {1'b0, row_i};
    item_o.px       = pos_x_i;
    item_o.py       = pos_y_i;
    item_o.wdist    = wall_dist_i;
    item_o.h        = screen_h_i;
    item_o.denom    = 10'(row2 - screen_h_i);
    if (!side_i && ray_x_dir_i == DIR_POS) begin
      item_o.fx = mx;
      item_o.fy = my + fr;
    end else if (!side_i && ray_x_dir_i == DIR_NEG) begin
      item_o.fx = mx + one;
      item_o.fy = my + fr;
    end else if (side_i && ray_y_dir_i == DIR_POS) begin
      item_o.fx = mx + fr;
      item_o.fy = my;
    end else begin
      item_o.fx = mx + fr;
      item_o.fy = my + one;
    end
  end

endmodule
`default_nettype wire

// File: sv/fctc_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none
module fctc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  fctc_pkg::item_t      item_i,
  output logic                 full_o,
  output logic                 pop_o,
  output fctc_pkg::item_t      item_o
);
  import fctc_pkg::*;

  item_t           mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_AW:0]   cnt_q, cnt_d;

  always_comb begin
    pop_o  = (cnt_q != '0);
    item_o = mem_q[rd_q];
    full_o = (cnt_q == (Q_AW+1)'(Q_DEPTH));
    wr_d   = push_i ? wr_q + 1'b1 : wr_q;
    rd_d   = pop_o ? rd_q + 1'b1 : rd_q;
    cnt_d  = cnt_q + (Q_AW+1)'(push_i) - (Q_AW+1)'(pop_o);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/fctc_back.sv
// Back end: pipelined row distance and weight division, blend and texture wrap.
`default_nettype none
module fctc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  fctc_pkg::item_t      item_i,
  input  wire logic [10:0]     tex_w_i,
  input  wire logic [10:0]     tex_h_i,
  output logic                 valid_o,
  output logic [9:0]           out_column_o,
  output logic [9:0]           floor_row_o,
  output logic [10:0]          ceil_row_o,
  output logic [9:0]           tex_x_o,
  output logic [9:0]           tex_y_o
);
  import fctc_pkg::*;

  localparam int unsigned PX_W = W_BITS + 1 + FPT_W;
  localparam int unsigned SUM_W = PX_W + 1;

  back_t             stg_q [NSTG+1];
  logic [NSTG:0]     vld_q;
  logic [2:0]        mv_q;

  logic [W_BITS:0]   w, omw;
  logic [PX_W-1:0]   wfx_q, wfy_q, opx_q, opy_q;
  logic [SUM_W-1:0]  sx, sy;
  logic [15:0]       frx_q, fry_q;
  logic [26:0]       tpx_q, tpy_q;
  logic [9:0]        col1_q, col2_q, col3_q, row1_q, row2_q, row3_q;
  logic [10:0]       ceil1_q, ceil2_q, ceil3_q;
  back_t             b0;
  back_t             bl;

  always_comb begin
    b0      = '0;
    b0.it   = item_i;
    bl      = stg_q[NSTG];
    w       = bl.sat ? (W_BITS+1)'(1) << FRAC_BITS : {1'b0, bl.wq};
    omw     = ((W_BITS+1)'(1) << FRAC_BITS) - w;
    sx      = SUM_W'(wfx_q) + SUM_W'(opx_q);
    sy      = SUM_W'(wfy_q) + SUM_W'(opy_q);
  end

  always_ff @(posedge clk_i) begin
    stg_q[0] <= b0;
    for (int unsigned s = 0; s < NSTG; s++) begin
      stg_q[s+1] <= back_step(stg_q[s], s);
    end
    wfx_q   <= PX_W'(w * bl.it.fx);
    wfy_q   <= PX_W'(w * bl.it.fy);
    opx_q   <= PX_W'(omw * bl.it.px);
    opy_q   <= PX_W'(omw * bl.it.py);
    col1_q  <= bl.it.column;
    row1_q  <= bl.it.row;
    ceil1_q <= bl.it.ceil_row;
    // Only the fraction of the blended point matters after the wrap.
    frx_q   <= sx[2*FRAC_BITS-1:FRAC_BITS];
    fry_q   <= sy[2*FRAC_BITS-1:FRAC_BITS];
    col2_q  <= col1_q;
    row2_q  <= row1_q;
    ceil2_q <= ceil1_q;
    tpx_q   <= frx_q * tex_clamp(tex_w_i);
    tpy_q   <= fry_q * tex_clamp(tex_h_i);
    col3_q  <= col2_q;
    row3_q  <= row2_q;
    ceil3_q <= ceil2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      mv_q  <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-1:0], valid_i};
      mv_q  <= {mv_q[1:0], vld_q[NSTG]};
    end
  end

  assign valid_o      = mv_q[2];
  assign out_column_o = col3_q;
  assign floor_row_o  = row3_q;
  assign ceil_row_o   = ceil3_q;
  assign tex_x_o      = tpx_q[FRAC_BITS+9:FRAC_BITS];
  assign tex_y_o      = tpy_q[FRAC_BITS+9:FRAC_BITS];

endmodule
`default_nettype wire

// File: sv/floor_texture_coordinate_caster.sv
// Top level of the floor texture coordinate caster: register port, front end, queue, back end.
// A request is written into the queue, popped into the back pipeline, and passes the divider
// stages and the blend, fraction and texel product registers before the result strobe rises.
// Throughput: one request per cycle; the bit-per-stage dividers are fully pipelined.
// The receiver cannot stall, so the queue drains every cycle and busy stays low.
// Reset clears the registers to height 480 and texture size 64 by 64, and empties the
// queue and all pipeline valid bits.
`default_nettype none
module floor_texture_coordinate_caster (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [9:0]         column_i,
  input  wire logic [9:0]         row_i,
  input  wire logic               side_i,
  input  wire logic [1:0]         ray_x_dir_i,
  input  wire logic [1:0]         ray_y_dir_i,
  input  wire logic [5:0]         map_x_i,
  input  wire logic [5:0]         map_y_i,
  input  wire logic [15:0]        wall_hit_frac_i,
  input  wire logic [23:0]        wall_dist_i,
  input  wire logic signed [10:0] draw_end_i,
  input  wire logic [21:0]        pos_x_i,
  input  wire logic [21:0]        pos_y_i,
  output logic                    strobe_o,
  output logic [9:0]              out_column_o,
  output logic [9:0]              floor_row_o,
  output logic [10:0]             ceil_row_o,
  output logic [9:0]              tex_x_o,
  output logic [9:0]              tex_y_o
);
  import fctc_pkg::*;

  logic [10:0] screen_h_q, tex_w_q, tex_h_q;
  logic        wr_en;
  logic        push, pop;
  item_t       f_item, q_item;

  // Registers sit at word addresses; a write lands in the access cycle.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_h_q <= 11'd480;
      tex_w_q    <= 11'd64;
      tex_h_q    <= 11'd64;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SCREEN_H: screen_h_q <= pwdata[10:0];
        REG_TEX_W:    tex_w_q    <= pwdata[10:0];
        REG_TEX_H:    tex_h_q    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SCREEN_H: prdata = {21'd0, screen_h_q};
      REG_TEX_W:    prdata = {21'd0, tex_w_q};
      REG_TEX_H:    prdata = {21'd0, tex_h_q};
      default:      prdata = '0;
    endcase
  end

  // The front end drops requests that have no floor pixel and sends the rest on.
  fctc_front u_front (
    .start_i         (start),
    .busy_i          (busy),
    .screen_h_i      (screen_h_q),
    .column_i        (column_i),
    .row_i           (row_i),
    .side_i          (side_i),
    .ray_x_dir_i     (ray_x_dir_i),
    .ray_y_dir_i     (ray_y_dir_i),
    .map_x_i         (map_x_i),
    .map_y_i         (map_y_i),
    .wall_hit_frac_i (wall_hit_frac_i),
    .wall_dist_i     (wall_dist_i),
    .draw_end_i      (draw_end_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .push_o          (push),
    .item_o          (f_item)
  );

  fctc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .full_o (busy),
    .pop_o  (pop),
    .item_o (q_item)
  );

  // The back end computes distance, weight, blend and wrapped texel coordinates.
  fctc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (pop),
    .item_i       (q_item),
    .tex_w_i      (tex_w_q),
    .tex_h_i      (tex_h_q),
    .valid_o      (strobe_o),
    .out_column_o (out_column_o),
    .floor_row_o  (floor_row_o),
    .ceil_row_o   (ceil_row_o),
    .tex_x_o      (tex_x_o),
    .tex_y_o      (tex_y_o)
  );

endmodule
`default_nettype wire
